FILE: hdl/ths_pkg.sv
// Shared types and constants for the three-axis homing supervisor.
package ths_pkg;

    // Item command codes.
    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_HOME = 2'd1,
        CMD_MOVE = 2'd2
    } command_t;

    // Reasons for refusing a request.
    typedef enum logic [2:0] {
        REASON_NONE     = 3'd0,
        REASON_BAD_AXIS = 3'd1,
        REASON_HALTED   = 3'd2,
        REASON_ALARM    = 3'd3,
        REASON_BUSY     = 3'd4
    } reason_t;

    // Homing sequence phases.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_START  = 3'd1,
        PH_ELBOW  = 3'd2,
        PH_SETTLE = 3'd3,
        PH_PAIR   = 3'd4
    } phase_t;

    // Axis number that names no axis.
    localparam logic [1:0] AXIS_INVALID = 2'd3;

    // Per-axis masks: bit 0 base, bit 1 shoulder, bit 2 elbow.
    localparam logic [2:0] MASK_NONE     = 3'b000;
    localparam logic [2:0] MASK_BASE     = 3'b001;
    localparam logic [2:0] MASK_SHOULDER = 3'b010;
    localparam logic [2:0] MASK_PAIR     = 3'b011;
    localparam logic [2:0] MASK_ELBOW    = 3'b100;
    localparam logic [2:0] MASK_ALL      = 3'b111;

    // Settle counter limits and reset value of the settle register.
    localparam logic [7:0] SETTLE_MAX         = 8'hFF;
    localparam logic [7:0] SETTLE_TICKS_RESET = 8'd10;

endpackage

FILE: hdl/ths_if.sv
// Channel interfaces: command items, result items and the settle register write.

interface ths_item_if #(
    parameter int POS_BITS = 22
);
    logic                       valid;
    logic                       ready;
    logic [1:0]                 command;
    logic [1:0]                 axis;
    logic [2:0]                 axis_alarm;
    logic [2:0]                 axis_halted;
    logic [2:0]                 axis_homing_busy;
    logic [2:0]                 axis_home_done;
    logic [2:0]                 axis_in_motion;
    logic signed [POS_BITS-1:0] current_pos;
    logic signed [POS_BITS-1:0] target_pos;

    modport source (
        output valid, command, axis, axis_alarm, axis_halted, axis_homing_busy,
               axis_home_done, axis_in_motion, current_pos, target_pos,
        input  ready
    );
    modport sink (
        input  valid, command, axis, axis_alarm, axis_halted, axis_homing_busy,
               axis_home_done, axis_in_motion, current_pos, target_pos,
        output ready
    );
endinterface

interface ths_result_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic [2:0] reject_reason;
    logic [2:0] stop_mask;
    logic [2:0] hiz_mask;
    logic [2:0] home_start_mask;
    logic       move_start;
    logic       move_reverse;
    logic       busy_res;
    logic [2:0] homing_phase;
    logic [2:0] home_fail_mask;

    modport source (
        output valid, accepted, reject_reason, stop_mask, hiz_mask, home_start_mask,
               move_start, move_reverse, busy_res, homing_phase, home_fail_mask,
        input  ready
    );
    modport sink (
        input  valid, accepted, reject_reason, stop_mask, hiz_mask, home_start_mask,
               move_start, move_reverse, busy_res, homing_phase, home_fail_mask,
        output ready
    );
endinterface

interface ths_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

FILE: hdl/three_axis_homing_supervisor.sv
// Top level of the three-axis homing supervisor.
//
// Usage: each beat on the item channel is a poll tick, a homing request or a
// move request, together with the current driver status flags of the base,
// shoulder and elbow axes. Every item gives exactly one beat on the result
// channel, in order. The cfg channel writes the settle tick count; it is always
// ready and should only be written while no item is in flight.
// Flow: an item accepted at a clock edge is captured in the input register,
// evaluated against the homing phase, settle counter and moving marks, and its
// result is loaded into the output register, from which it is offered.
// Throughput is one item per cycle while the receiver takes results, set by the
// single evaluation step between the input register and the output register.
// When the receiver stalls, the result holds and the input register keeps one
// more item; the item channel drops ready only when both are occupied.
// Reset clears both stages, puts the sequence in idle with no axis marked
// moving, clears the settle counter and loads a settle count of 10 ticks.
module three_axis_homing_supervisor #(
    parameter int POS_BITS = 22
) (
    input  logic         clk,
    input  logic         rst_n,
    ths_item_if.sink     item,
    ths_result_if.source result,
    ths_cfg_if.sink      cfg
);

    // Input register stage.
    logic                       s1_valid_reg;
    logic [1:0]                 cmd_reg;
    logic [1:0]                 axis_reg;
    logic [2:0]                 alarm_reg;
    logic [2:0]                 halted_reg;
    logic [2:0]                 hbusy_reg;
    logic [2:0]                 hdone_reg;
    logic [2:0]                 motion_reg;
    logic signed [POS_BITS-1:0] cur_reg;
    logic signed [POS_BITS-1:0] tgt_reg;

    // Supervisor state.
    ths_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      settle_count_reg, settle_count_next;
    logic [2:0]      marks_reg, marks_next;
    logic [7:0]      settle_ticks_reg;

    // Output register stage.
    logic       out_valid_reg;
    logic       accepted_reg, accepted_next;
    logic [2:0] reason_reg, reason_next;
    logic [2:0] stop_reg, stop_next;
    logic [2:0] hiz_reg, hiz_next;
    logic [2:0] hstart_reg, hstart_next;
    logic       mstart_reg, mstart_next;
    logic       mrev_reg, mrev_next;
    logic       busy_reg, busy_next;
    logic [2:0] hphase_reg;
    logic [2:0] fail_reg, fail_next;

    logic       out_load;
    logic       in_take;
    logic [7:0] settle_inc;
    logic [2:0] axis_bit;
    logic [2:0] stopped_marks;

    // Handshake: the output stage loads when empty or drained this cycle.
    assign out_load   = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || out_load;
    assign in_take    = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    // Settle register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_ticks_reg <= ths_pkg::SETTLE_TICKS_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            settle_ticks_reg <= cfg.data;
        end
    end

    // Input stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    // Input stage payload.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg    <= item.command;
            axis_reg   <= item.axis;
            alarm_reg  <= item.axis_alarm;
            halted_reg <= item.axis_halted;
            hbusy_reg  <= item.axis_homing_busy;
            hdone_reg  <= item.axis_home_done;
            motion_reg <= item.axis_in_motion;
            cur_reg    <= item.current_pos;
            tgt_reg    <= item.target_pos;
        end
    end

    // State registers advance when an item moves into the output stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= ths_pkg::PH_IDLE;
            settle_count_reg <= 8'd0;
            marks_reg        <= ths_pkg::MASK_NONE;
        end
        else if (out_load)
        begin
            phase_reg        <= phase_next;
            settle_count_reg <= settle_count_next;
            marks_reg        <= marks_next;
        end
    end

    assign settle_inc = (settle_count_reg == ths_pkg::SETTLE_MAX) ?
                        ths_pkg::SETTLE_MAX : settle_count_reg + 8'd1;
    assign axis_bit      = 3'b001 << axis_reg;
    assign stopped_marks = marks_reg & ~motion_reg;

    // Next state and result fields for the item in the input register.
    always_comb
    begin
        phase_next        = phase_reg;
        settle_count_next = settle_count_reg;
        marks_next        = marks_reg;
        accepted_next     = 1'b0;
        reason_next       = ths_pkg::REASON_NONE;
        stop_next         = ths_pkg::MASK_NONE;
        hiz_next          = ths_pkg::MASK_NONE;
        hstart_next       = ths_pkg::MASK_NONE;
        mstart_next       = 1'b0;
        mrev_next         = 1'b0;
        fail_next         = ths_pkg::MASK_NONE;

        case (ths_pkg::command_t'(cmd_reg))
            ths_pkg::CMD_TICK:
            begin
                // Homing sequence step.
                case (phase_reg)
                    ths_pkg::PH_START:
                    begin
                        if (alarm_reg != ths_pkg::MASK_NONE)
                        begin
                            phase_next = ths_pkg::PH_IDLE;
                        end
                        else
                        begin
                            stop_next   = ths_pkg::MASK_PAIR;
                            hstart_next = ths_pkg::MASK_ELBOW;
                            phase_next  = ths_pkg::PH_ELBOW;
                        end
                    end
                    ths_pkg::PH_ELBOW:
                    begin
                        if ((hbusy_reg & ths_pkg::MASK_ELBOW) == ths_pkg::MASK_NONE)
                        begin
                            if ((hdone_reg & ths_pkg::MASK_ELBOW) == ths_pkg::MASK_NONE)
                            begin
                                fail_next  = ths_pkg::MASK_ELBOW;
                                phase_next = ths_pkg::PH_IDLE;
                            end
                            else
                            begin
                                settle_count_next = 8'd0;
                                phase_next        = ths_pkg::PH_SETTLE;
                            end
                        end
                    end
                    ths_pkg::PH_SETTLE:
                    begin
                        settle_count_next = settle_inc;
                        if (settle_inc >= settle_ticks_reg)
                        begin
                            hstart_next = ths_pkg::MASK_PAIR;
                            phase_next  = ths_pkg::PH_PAIR;
                        end
                    end
                    ths_pkg::PH_PAIR:
                    begin
                        if ((hbusy_reg & ths_pkg::MASK_PAIR) == ths_pkg::MASK_NONE)
                        begin
                            // A failed axis stops its partner if still moving.
                            if (!hdone_reg[0])
                            begin
                                fail_next[0] = 1'b1;
                                stop_next[1] = motion_reg[1];
                            end
                            if (!hdone_reg[1])
                            begin
                                fail_next[1] = 1'b1;
                                stop_next[0] = motion_reg[0];
                            end
                            phase_next = ths_pkg::PH_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_next = ths_pkg::PH_IDLE;
                    end
                endcase

                // Motion check: unmark stopped axes, float everything on an alarm on one of them.
                marks_next = marks_reg & motion_reg;
                if ((stopped_marks & alarm_reg) != ths_pkg::MASK_NONE)
                begin
                    hiz_next = ths_pkg::MASK_ALL;
                end
            end
            ths_pkg::CMD_HOME:
            begin
                if (phase_reg != ths_pkg::PH_IDLE || marks_reg != ths_pkg::MASK_NONE)
                begin
                    reason_next = ths_pkg::REASON_BUSY;
                end
                else
                begin
                    phase_next    = ths_pkg::PH_START;
                    accepted_next = 1'b1;
                end
            end
            ths_pkg::CMD_MOVE:
            begin
                if (axis_reg == ths_pkg::AXIS_INVALID)
                begin
                    reason_next = ths_pkg::REASON_BAD_AXIS;
                end
                else if ((halted_reg & axis_bit) != ths_pkg::MASK_NONE)
                begin
                    reason_next = ths_pkg::REASON_HALTED;
                end
                else if ((alarm_reg & axis_bit) != ths_pkg::MASK_NONE)
                begin
                    reason_next = ths_pkg::REASON_ALARM;
                end
                else if (phase_reg != ths_pkg::PH_IDLE ||
                         (marks_reg & axis_bit) != ths_pkg::MASK_NONE)
                begin
                    reason_next = ths_pkg::REASON_BUSY;
                end
                else
                begin
                    accepted_next = 1'b1;
                    mstart_next   = 1'b1;
                    mrev_next     = cur_reg > tgt_reg;
                    marks_next    = marks_reg | axis_bit;
                end
            end
            default:
            begin
                // Unused command code leaves the state alone.
                phase_next = phase_reg;
            end
        endcase

        busy_next = (phase_next != ths_pkg::PH_IDLE) || (marks_next != ths_pkg::MASK_NONE);
    end

    // Output stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result.ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Output stage payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            accepted_reg <= accepted_next;
            reason_reg   <= reason_next;
            stop_reg     <= stop_next;
            hiz_reg      <= hiz_next;
            hstart_reg   <= hstart_next;
            mstart_reg   <= mstart_next;
            mrev_reg     <= mrev_next;
            busy_reg     <= busy_next;
            hphase_reg   <= phase_next;
            fail_reg     <= fail_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.accepted        = accepted_reg;
    assign result.reject_reason   = reason_reg;
    assign result.stop_mask       = stop_reg;
    assign result.hiz_mask        = hiz_reg;
    assign result.home_start_mask = hstart_reg;
    assign result.move_start      = mstart_reg;
    assign result.move_reverse    = mrev_reg;
    assign result.busy_res        = busy_reg;
    assign result.homing_phase    = hphase_reg;
    assign result.home_fail_mask  = fail_reg;

    // An accepted request never carries a reject reason.
    a_accept_no_reason: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && accepted_reg) |-> (reason_reg == ths_pkg::REASON_NONE))
        else $error("accepted result carries a reject reason");

    // A direction is only reported with a move start.
    a_reverse_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && mrev_reg) |-> mstart_reg)
        else $error("move_reverse without move_start");

    // A running homing sequence always reports busy.
    a_phase_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && hphase_reg != ths_pkg::PH_IDLE) |-> busy_reg)
        else $error("homing phase active but busy_res low");

    // High impedance goes to all axes or none.
    a_hiz_all: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (hiz_reg == ths_pkg::MASK_NONE || hiz_reg == ths_pkg::MASK_ALL))
        else $error("partial high-impedance mask");

    // An item held in the input stage is not dropped while the output stalls.
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_load) |=> s1_valid_reg)
        else $error("stalled item lost from the input register");

endmodule

FILE: sim/tb_top.sv
// Testbench for the three-axis homing supervisor: directed and random items checked beat by beat.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ths_pkg::*;

    localparam int POS_BITS = 22;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] AXIS_BASE = 2'd0;
    localparam logic [1:0] AXIS_SHOULDER = 2'd1;
    localparam logic [1:0] AXIS_ELBOW = 2'd2;
    localparam logic signed [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};
    localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
    localparam logic signed [POS_BITS-1:0] POS_ZERO = '0;
    localparam int MAX_REPORTS = 10;
    localparam int PRESSURE_AT = 400;
    localparam int PRESSURE_CYCLES = 300;

    // One status item as it is offered on the item channel.
    typedef struct {
        logic [1:0]                 command;
        logic [1:0]                 axis;
        logic [2:0]                 alarm;
        logic [2:0]                 halted;
        logic [2:0]                 homing_busy;
        logic [2:0]                 home_done;
        logic [2:0]                 in_motion;
        logic signed [POS_BITS-1:0] current_pos;
        logic signed [POS_BITS-1:0] target_pos;
    } status_item_t;

    // One verdict as it comes back on the result channel.
    typedef struct {
        logic       accepted;
        logic [2:0] reject_reason;
        logic [2:0] stop_mask;
        logic [2:0] hiz_mask;
        logic [2:0] home_start_mask;
        logic       move_start;
        logic       move_reverse;
        logic       busy_res;
        logic [2:0] homing_phase;
        logic [2:0] home_fail_mask;
    } verdict_t;

    // Tracks the supervisor state and holds the verdicts still owed by the block.
    class homing_scoreboard;
        logic [7:0] settle_ticks;
        phase_t     phase;
        logic [7:0] settle_count;
        logic [2:0] moving_marks;
        verdict_t   expected_verdicts[$];
        int         failures;
        int         reported;

        function new();
            settle_ticks = SETTLE_TICKS_RESET;
            phase = PH_IDLE;
            settle_count = 8'd0;
            moving_marks = MASK_NONE;
            failures = 0;
            reported = 0;
        endfunction

        function void set_settle_ticks(logic [7:0] value);
            settle_ticks = value;
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction

        // Advances the supervisor by one accepted item and queues its verdict.
        function void note_item(status_item_t it);
            verdict_t v;
            int a;
            v = '{default: '0};
            if (it.command == CMD_TICK)
            begin
                // Homing sequence step comes first.
                case (phase)
                    PH_START:
                        if (it.alarm != MASK_NONE)
                        begin
                            phase = PH_IDLE;
                        end
                        else
                        begin
                            v.stop_mask |= MASK_PAIR;
                            v.home_start_mask |= MASK_ELBOW;
                            phase = PH_ELBOW;
                        end
                    PH_ELBOW:
                        if ((it.homing_busy & MASK_ELBOW) == MASK_NONE)
                        begin
                            if ((it.home_done & MASK_ELBOW) == MASK_NONE)
                            begin
                                v.home_fail_mask |= MASK_ELBOW;
                                phase = PH_IDLE;
                            end
                            else
                            begin
                                settle_count = 8'd0;
                                phase = PH_SETTLE;
                            end
                        end
                    PH_SETTLE:
                        begin
                            if (settle_count != SETTLE_MAX)
                                settle_count = settle_count + 8'd1;
                            if (settle_count >= settle_ticks)
                            begin
                                v.home_start_mask |= MASK_PAIR;
                                phase = PH_PAIR;
                            end
                        end
                    PH_PAIR:
                        if ((it.homing_busy & MASK_PAIR) == MASK_NONE)
                        begin
                            // A failed axis stops its partner if the partner still moves.
                            if ((it.home_done & MASK_BASE) == MASK_NONE)
                            begin
                                v.home_fail_mask |= MASK_BASE;
                                if ((it.in_motion & MASK_SHOULDER) != MASK_NONE)
                                    v.stop_mask |= MASK_SHOULDER;
                            end
                            if ((it.home_done & MASK_SHOULDER) == MASK_NONE)
                            begin
                                v.home_fail_mask |= MASK_SHOULDER;
                                if ((it.in_motion & MASK_BASE) != MASK_NONE)
                                    v.stop_mask |= MASK_BASE;
                            end
                            phase = PH_IDLE;
                        end
                    default:
                        phase = PH_IDLE;
                endcase
                // Marked axes that have stopped are released; an alarm on one
                // of them puts every axis into high impedance.
                for (a = 0; a < 3; a++)
                begin
                    if (moving_marks[a] && !it.in_motion[a])
                    begin
                        if (it.alarm[a])
                            v.hiz_mask = MASK_ALL;
                        moving_marks[a] = 1'b0;
                    end
                end
            end
            else if (it.command == CMD_HOME)
            begin
                if (phase != PH_IDLE || moving_marks != MASK_NONE)
                begin
                    v.reject_reason = REASON_BUSY;
                end
                else
                begin
                    phase = PH_START;
                    v.accepted = 1'b1;
                end
            end
            else if (it.command == CMD_MOVE)
            begin
                // Refusals are checked in priority order.
                if (it.axis == AXIS_INVALID)
                    v.reject_reason = REASON_BAD_AXIS;
                else if (it.halted[it.axis])
                    v.reject_reason = REASON_HALTED;
                else if (it.alarm[it.axis])
                    v.reject_reason = REASON_ALARM;
                else if (phase != PH_IDLE || moving_marks[it.axis])
                    v.reject_reason = REASON_BUSY;
                else
                begin
                    v.accepted = 1'b1;
                    v.move_start = 1'b1;
                    v.move_reverse = (it.current_pos > it.target_pos);
                    moving_marks[it.axis] = 1'b1;
                end
            end
            v.busy_res = (phase != PH_IDLE) || (moving_marks != MASK_NONE);
            v.homing_phase = phase;
            expected_verdicts.push_back(v);
        endfunction

        // Compares one result beat with the oldest verdict owed.
        function void check_result(verdict_t got);
            verdict_t want;
            if (expected_verdicts.size() == 0)
            begin
                failures++;
                if (reported < MAX_REPORTS)
                begin
                    reported++;
                    $display("ERROR: result beat at %0t with no item outstanding", $realtime);
                end
                return;
            end
            want = expected_verdicts.pop_front();
            if (got.accepted !== want.accepted || got.reject_reason !== want.reject_reason ||
                got.stop_mask !== want.stop_mask || got.hiz_mask !== want.hiz_mask ||
                got.home_start_mask !== want.home_start_mask ||
                got.move_start !== want.move_start || got.move_reverse !== want.move_reverse ||
                got.busy_res !== want.busy_res || got.homing_phase !== want.homing_phase ||
                got.home_fail_mask !== want.home_fail_mask)
            begin
                failures++;
                if (reported < MAX_REPORTS)
                begin
                    reported++;
                    $display("ERROR: result mismatch at %0t", $realtime);
                    $display("  expected acc=%0d rsn=%0d stop=%b hiz=%b home=%b",
                             want.accepted, want.reject_reason, want.stop_mask,
                             want.hiz_mask, want.home_start_mask);
                    $display("           mv=%0d rev=%0d busy=%0d ph=%0d fail=%b",
                             want.move_start, want.move_reverse, want.busy_res,
                             want.homing_phase, want.home_fail_mask);
                    $display("  actual   acc=%0d rsn=%0d stop=%b hiz=%b home=%b",
                             got.accepted, got.reject_reason, got.stop_mask,
                             got.hiz_mask, got.home_start_mask);
                    $display("           mv=%0d rev=%0d busy=%0d ph=%0d fail=%b",
                             got.move_start, got.move_reverse, got.busy_res,
                             got.homing_phase, got.home_fail_mask);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    homing_scoreboard scb;
    int send_mode;
    int recv_mode;
    int results_seen;

    ths_item_if #(.POS_BITS(POS_BITS)) item_ch ();
    ths_result_if result_ch ();
    ths_cfg_if cfg_ch ();

    three_axis_homing_supervisor #(
        .POS_BITS(POS_BITS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #5 clk = ~clk;

    // Wait length for one beat: none, uniform up to 19, or mostly none.
    function automatic int draw_wait(int mode);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return $urandom_range(0, 19);
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
    endfunction

    function automatic status_item_t make_item(logic [1:0] command, logic [1:0] axis,
                                               logic [2:0] alarm, logic [2:0] halted,
                                               logic [2:0] homing_busy, logic [2:0] home_done,
                                               logic [2:0] in_motion,
                                               logic signed [POS_BITS-1:0] current_pos,
                                               logic signed [POS_BITS-1:0] target_pos);
        status_item_t it;
        it.command = command;
        it.axis = axis;
        it.alarm = alarm;
        it.halted = halted;
        it.homing_busy = homing_busy;
        it.home_done = home_done;
        it.in_motion = in_motion;
        it.current_pos = current_pos;
        it.target_pos = target_pos;
        return it;
    endfunction

    // Random item: mostly plausible driver status so homing runs to its end.
    function automatic status_item_t random_item(int tick_pct);
        status_item_t it;
        int roll;
        logic [31:0] raw;
        roll = $urandom_range(0, 99);
        if (roll < tick_pct)
            it.command = CMD_TICK;
        else if (roll < tick_pct + (100 - tick_pct) / 3)
            it.command = CMD_HOME;
        else if (roll < 97)
            it.command = CMD_MOVE;
        else
            it.command = CMD_UNUSED;
        it.axis = ($urandom_range(0, 9) == 0) ? AXIS_INVALID : 2'($urandom_range(0, 2));
        it.alarm = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(1, 7)) : MASK_NONE;
        it.halted = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(1, 7)) : MASK_NONE;
        it.homing_busy = 3'($urandom_range(0, 7));
        it.home_done = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7)) : MASK_ALL;
        it.in_motion = 3'($urandom_range(0, 7));
        raw = $urandom();
        it.current_pos = raw[POS_BITS-1:0];
        raw = $urandom();
        it.target_pos = raw[POS_BITS-1:0];
        roll = $urandom_range(0, 15);
        if (roll == 0)
            it.current_pos = POS_MIN;
        else if (roll == 1)
            it.current_pos = POS_MAX;
        else if (roll == 2)
            it.target_pos = it.current_pos;
        return it;
    endfunction

    // Offers one item beat and records it once the block takes it.
    task automatic send_item(input status_item_t it);
        int gap;
        gap = draw_wait(send_mode);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.command <= it.command;
        item_ch.axis <= it.axis;
        item_ch.axis_alarm <= it.alarm;
        item_ch.axis_halted <= it.halted;
        item_ch.axis_homing_busy <= it.homing_busy;
        item_ch.axis_home_done <= it.home_done;
        item_ch.axis_in_motion <= it.in_motion;
        item_ch.current_pos <= it.current_pos;
        item_ch.target_pos <= it.target_pos;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        scb.note_item(it);
    endtask

    // Stops offering and lets every outstanding result drain.
    task automatic drain_items();
        item_ch.valid <= 1'b0;
        while (scb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_settle(input logic [7:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        scb.set_settle_ticks(value);
    endtask

    // Result side: random stalls, one long hold-off to back the block up.
    initial
    begin : result_sink
        int stall;
        bit held_off;
        verdict_t got;
        held_off = 1'b0;
        recv_mode = 0;
        results_seen = 0;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (results_seen % 40 == 0)
                recv_mode = $urandom_range(0, 2);
            if (!held_off && results_seen == PRESSURE_AT)
            begin
                held_off = 1'b1;
                stall = PRESSURE_CYCLES;
            end
            else
            begin
                stall = draw_wait(recv_mode);
            end
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (result_ch.valid !== 1'b1);
            got.accepted = result_ch.accepted;
            got.reject_reason = result_ch.reject_reason;
            got.stop_mask = result_ch.stop_mask;
            got.hiz_mask = result_ch.hiz_mask;
            got.home_start_mask = result_ch.home_start_mask;
            got.move_start = result_ch.move_start;
            got.move_reverse = result_ch.move_reverse;
            got.busy_res = result_ch.busy_res;
            got.homing_phase = result_ch.homing_phase;
            got.home_fail_mask = result_ch.home_fail_mask;
            scb.check_result(got);
            results_seen++;
        end
    end

    // Stimulus: directed sequences, then random phases at several settle counts.
    initial
    begin : stimulus
        int phase_idx;
        int i;
        int phase_items[4];
        int phase_ticks[4];
        logic [7:0] phase_settle[4];
        scb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        send_mode = 0;
        item_ch.valid = 1'b0;
        item_ch.command = CMD_TICK;
        item_ch.axis = AXIS_BASE;
        item_ch.axis_alarm = MASK_NONE;
        item_ch.axis_halted = MASK_NONE;
        item_ch.axis_homing_busy = MASK_NONE;
        item_ch.axis_home_done = MASK_NONE;
        item_ch.axis_in_motion = MASK_NONE;
        item_ch.current_pos = POS_ZERO;
        item_ch.target_pos = POS_ZERO;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = 8'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle tick with all flags set and unused code, then move refusals.
        send_mode = 2;
        send_item(make_item(CMD_TICK, AXIS_INVALID, MASK_ALL, MASK_ALL, MASK_ALL, MASK_ALL,
                            MASK_ALL, POS_MAX, POS_MIN));
        send_item(make_item(CMD_UNUSED, AXIS_BASE, MASK_ALL, MASK_NONE, MASK_ALL, MASK_NONE,
                            MASK_ALL, POS_MIN, POS_MAX));
        send_item(make_item(CMD_MOVE, AXIS_INVALID, MASK_NONE, MASK_NONE, MASK_NONE, MASK_NONE,
                            MASK_NONE, POS_ZERO, POS_ZERO));
        send_item(make_item(CMD_MOVE, AXIS_BASE, MASK_BASE, MASK_BASE, MASK_NONE, MASK_NONE,
                            MASK_NONE, POS_ZERO, POS_ZERO));
        send_item(make_item(CMD_MOVE, AXIS_SHOULDER, MASK_SHOULDER, MASK_BASE, MASK_NONE,
                            MASK_NONE, MASK_NONE, POS_ZERO, POS_ZERO));
        // Accepted move in reverse, then busy refusals while it is marked.
        send_item(make_item(CMD_MOVE, AXIS_BASE, MASK_ELBOW, MASK_SHOULDER, MASK_NONE, MASK_NONE,
                            MASK_NONE, POS_MAX, POS_MIN));
        send_item(make_item(CMD_MOVE, AXIS_BASE, MASK_NONE, MASK_NONE, MASK_NONE, MASK_NONE,
                            MASK_NONE, POS_ZERO, POS_ZERO));
        send_item(make_item(CMD_HOME, AXIS_BASE, MASK_NONE, MASK_NONE, MASK_NONE, MASK_NONE,
                            MASK_NONE, POS_ZERO, POS_ZERO));
        // The base stops with an alarm: every axis goes to high impedance.
        send_item(make_item(CMD_TICK, AXIS_BASE, MASK_BASE, MASK_NONE, MASK_NONE, MASK_NONE,
                            MASK_NONE, POS_ZERO, POS_ZERO));
        send_item(make_item(CMD_MOVE, AXIS_ELBOW, MASK_NONE, MASK_NONE, MASK_NONE, MASK_NONE,
                            MASK_NONE, POS_MIN, POS_MAX));
        send_item(make_item(CMD_MOVE, AXIS_SHOULDER, MASK_NONE, MASK_NONE, MASK_NONE, MASK_NONE,
                            MASK_NONE, POS_ZERO, POS_ZERO));
        send_item(make_item(CMD_TICK, AXIS_BASE, MASK_ELBOW, MASK_NONE, MASK_NONE, MASK_NONE,
                            MASK_ELBOW, POS_ZERO, POS_ZERO));
        send_item(make_item(CMD_TICK, AXIS_BASE, MASK_NONE, MASK_NONE, MASK_NONE, MASK_NONE,
                            MASK_NONE, POS_ZERO, POS_ZERO));
        // Homing accepted, refused while running, aborted on an alarm.
        send_item(make_item(CMD_HOME, AXIS_BASE, MASK_NONE, MASK_NONE, MASK_NONE, MASK_NONE,
                            MASK_NONE, POS_ZERO, POS_ZERO));
        send_item(make_item(CMD_HOME, AXIS_BASE, MASK_NONE, MASK_NONE, MASK_NONE, MASK_NONE,
                            MASK_NONE, POS_ZERO, POS_ZERO));
        send_item(make_item(CMD_MOVE, AXIS_BASE, MASK_NONE, MASK_NONE, MASK_NONE, MASK_NONE,
                            MASK_NONE, POS_ZERO, POS_ZERO));
        send_item(make_item(CMD_TICK, AXIS_BASE, MASK_ELBOW, MASK_NONE, MASK_NONE, MASK_NONE,
                            MASK_NONE, POS_ZERO, POS_ZERO));
        // Elbow homing that ends without reaching home.
        send_item(make_item(CMD_HOME, AXIS_BASE, MASK_NONE, MASK_NONE, MASK_NONE, MASK_NONE,
                            MASK_NONE, POS_ZERO, POS_ZERO));
        send_item(make_item(CMD_TICK, AXIS_BASE, MASK_NONE, MASK_NONE, MASK_NONE, MASK_NONE,
                            MASK_NONE, POS_ZERO, POS_ZERO));
        send_item(make_item(CMD_TICK, AXIS_BASE, MASK_NONE, MASK_NONE, MASK_ELBOW, MASK_NONE,
                            MASK_NONE, POS_ZERO, POS_ZERO));
        send_item(make_item(CMD_TICK, AXIS_BASE, MASK_NONE, MASK_NONE, MASK_NONE, MASK_PAIR,
                            MASK_NONE, POS_ZERO, POS_ZERO));
        drain_items();

        // Full homing with no settle wait; the shoulder fails, the base is stopped.
        write_settle(8'd0);
        send_item(make_item(CMD_HOME, AXIS_BASE, MASK_NONE, MASK_NONE, MASK_NONE, MASK_NONE,
                            MASK_NONE, POS_ZERO, POS_ZERO));
        send_item(make_item(CMD_TICK, AXIS_BASE, MASK_NONE, MASK_NONE, MASK_NONE, MASK_NONE,
                            MASK_NONE, POS_ZERO, POS_ZERO));
        send_item(make_item(CMD_TICK, AXIS_BASE, MASK_NONE, MASK_NONE, MASK_PAIR, MASK_ELBOW,
                            MASK_NONE, POS_ZERO, POS_ZERO));
        send_item(make_item(CMD_TICK, AXIS_BASE, MASK_NONE, MASK_NONE, MASK_NONE, MASK_NONE,
                            MASK_NONE, POS_ZERO, POS_ZERO));
        send_item(make_item(CMD_TICK, AXIS_BASE, MASK_NONE, MASK_NONE, MASK_BASE, MASK_NONE,
                            MASK_NONE, POS_ZERO, POS_ZERO));
        send_item(make_item(CMD_TICK, AXIS_BASE, MASK_NONE, MASK_NONE, MASK_NONE, MASK_BASE,
                            MASK_ALL, POS_ZERO, POS_ZERO));
        drain_items();

        // Random phases; the long settle phase gets mostly ticks so it completes.
        phase_settle[0] = 8'($urandom_range(2, 12));
        phase_settle[1] = SETTLE_MAX;
        phase_settle[2] = 8'd0;
        phase_settle[3] = 8'd1;
        phase_items = '{300, 400, 200, 150};
        phase_ticks = '{55, 85, 50, 60};
        for (phase_idx = 0; phase_idx < 4; phase_idx++)
        begin
            write_settle(phase_settle[phase_idx]);
            for (i = 0; i < phase_items[phase_idx]; i++)
            begin
                if (i % 50 == 0)
                    send_mode = $urandom_range(0, 2);
                send_item(random_item(phase_ticks[phase_idx]));
            end
            drain_items();
        end

        repeat (5) @(posedge clk);
        if (scb.failures == 0 && scb.pending() == 0)
            $display("** three_axis_homing_supervisor: PASSED **");
        else
            $display("** three_axis_homing_supervisor: FAILED **");
        $finish;
    end

    // Hard limit on the run.
    initial
    begin : watchdog
        #5_000_000;
        $display("** three_axis_homing_supervisor: FAILED **");
        $finish;
    end

endmodule
